FILE: rtl/plex_pkg.sv
// Shared types and constants for the punctuation and operator lexer.
`timescale 1ns / 1ps
`default_nettype none

package plex_pkg;

  // Widths of the token fields
  localparam int KIND_W  = 5;
  localparam int START_W = 16;
  localparam int LEN_W   = 2;
  localparam int LINE_W  = 16;

  // Result queue depth; the input side stalls while fewer than four slots are free
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  // Headroom for the tokens of the byte in the input register plus the byte being accepted
  localparam int FIFO_ROOM  = 4;

  // One token as it leaves the lexer
  typedef struct packed {
    logic              last;
    logic [LINE_W-1:0]  line;
    logic [LEN_W-1:0]   length;
    logic [START_W-1:0] start;
    logic [KIND_W-1:0]  kind;
  } token_t;

endpackage

`default_nettype wire

FILE: rtl/plex_core.sv
// Lexer core: input register, one-byte lookahead state and token decode.
`timescale 1ns / 1ps
`default_nettype none

module plex_core #(
  parameter longint unsigned MAX_SOURCE_BYTES = 65536,
  parameter longint unsigned LINE_LIMIT       = 65535
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid_i,
  input  wire logic            in_ready_i,
  input  wire logic [7:0]      in_byte_i,
  output plex_pkg::token_t     tok0,
  output plex_pkg::token_t     tok1,
  output logic [1:0]           push_cnt
);
  import plex_pkg::*;

  localparam int POS_W = $clog2(MAX_SOURCE_BYTES);
  localparam int LNC_W = $clog2(LINE_LIMIT + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SOURCE_BYTES - 1);
  localparam logic [LNC_W-1:0] LINE_TOP = LNC_W'(LINE_LIMIT);

  // Token kinds
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd0;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd1;
  localparam logic [KIND_W-1:0] K_LBRACE  = 5'd2;
  localparam logic [KIND_W-1:0] K_RBRACE  = 5'd3;
  localparam logic [KIND_W-1:0] K_SEMI    = 5'd4;
  localparam logic [KIND_W-1:0] K_COMMA   = 5'd5;
  localparam logic [KIND_W-1:0] K_DOT     = 5'd6;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd7;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd8;
  localparam logic [KIND_W-1:0] K_SLASH   = 5'd9;
  localparam logic [KIND_W-1:0] K_STAR    = 5'd10;
  localparam logic [KIND_W-1:0] K_BANG    = 5'd11;
  localparam logic [KIND_W-1:0] K_EQUAL   = 5'd13;
  localparam logic [KIND_W-1:0] K_LESS    = 5'd15;
  localparam logic [KIND_W-1:0] K_GREATER = 5'd17;
  localparam logic [KIND_W-1:0] K_ERROR   = 5'd19;
  localparam logic [KIND_W-1:0] K_END     = 5'd20;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LESS  = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  typedef enum logic [2:0] {
    P_NONE, P_BANG, P_EQUAL, P_LESS, P_GREATER, P_SLASH
  } pend_t;

  // Registers
  logic              in_valid;
  logic [7:0]        in_byte;
  pend_t             pend, pend_next;
  logic [START_W-1:0] pend_start, pend_start_next;
  logic              in_comment, in_comment_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [LNC_W-1:0]  line, line_next;

  // Decode helpers
  logic              single_hit;
  logic [KIND_W-1:0] single_kind;
  pend_t             pair_code;
  logic [KIND_W-1:0] pend_base;
  logic [POS_W-1:0]  pos_inc;
  logic [LNC_W-1:0]  line_inc;

  // Token assembly
  logic              emit_pend;
  logic [KIND_W-1:0] pend_kind;
  logic [LEN_W-1:0]  pend_len;
  logic              run_fresh;
  logic              fresh_emit;
  logic [KIND_W-1:0] fresh_kind;
  logic [START_W-1:0] fresh_start;
  logic [LEN_W-1:0]  fresh_len;

  assign pos_inc  = (pos != POS_LAST) ? pos + POS_W'(1) : pos;
  assign line_inc = (line != LINE_TOP) ? line + LNC_W'(1) : line;

  // Single-character punctuation
  always_comb begin
    single_hit  = 1'b1;
    single_kind = K_LPAREN;
    case (in_byte)
      CH_LPAR:  single_kind = K_LPAREN;
      CH_RPAR:  single_kind = K_RPAREN;
      CH_LBRC:  single_kind = K_LBRACE;
      CH_RBRC:  single_kind = K_RBRACE;
      CH_SEMI:  single_kind = K_SEMI;
      CH_COMMA: single_kind = K_COMMA;
      CH_DOT:   single_kind = K_DOT;
      CH_MINUS: single_kind = K_MINUS;
      CH_PLUS:  single_kind = K_PLUS;
      CH_STAR:  single_kind = K_STAR;
      default:  single_hit  = 1'b0;
    endcase
  end

  // Characters that wait for one byte of lookahead
  always_comb begin
    case (in_byte)
      CH_BANG:  pair_code = P_BANG;
      CH_EQ:    pair_code = P_EQUAL;
      CH_LESS:  pair_code = P_LESS;
      CH_GT:    pair_code = P_GREATER;
      CH_SLASH: pair_code = P_SLASH;
      default:  pair_code = P_NONE;
    endcase
  end

  // One-character kind of the pending operator; the two-character kind is one above
  always_comb begin
    case (pend)
      P_BANG:    pend_base = K_BANG;
      P_EQUAL:   pend_base = K_EQUAL;
      P_LESS:    pend_base = K_LESS;
      P_GREATER: pend_base = K_GREATER;
      default:   pend_base = K_SLASH;
    endcase
  end

  // Next state and tokens for the byte in the input register
  always_comb begin
    pos_next        = pos;
    line_next       = line;
    pend_next       = pend;
    pend_start_next = pend_start;
    in_comment_next = in_comment;
    emit_pend       = 1'b0;
    pend_kind       = pend_base;
    pend_len        = LEN_W'(1);
    run_fresh       = 1'b0;
    fresh_emit      = 1'b0;
    fresh_kind      = K_ERROR;
    fresh_start     = START_W'(pos);
    fresh_len       = LEN_W'(1);

    if (in_valid) begin
      if (in_comment) begin
        if (in_byte == CH_NUL) begin
          fresh_emit = 1'b1;
          fresh_kind = K_END;
          fresh_len  = LEN_W'(0);
        end else begin
          pos_next = pos_inc;
          if (in_byte == CH_NL) begin
            line_next       = line_inc;
            in_comment_next = 1'b0;
          end
        end
      end else if (pend == P_SLASH) begin
        pend_next = P_NONE;
        if (in_byte == CH_SLASH) begin
          in_comment_next = 1'b1;
          pos_next        = pos_inc;
        end else begin
          emit_pend = 1'b1;
          run_fresh = 1'b1;
        end
      end else if (pend != P_NONE) begin
        pend_next = P_NONE;
        emit_pend = 1'b1;
        if (in_byte == CH_EQ) begin
          pend_kind = pend_base + KIND_W'(1);
          pend_len  = LEN_W'(2);
          pos_next  = pos_inc;
        end else begin
          run_fresh = 1'b1;
        end
      end else begin
        run_fresh = 1'b1;
      end
    end

    // Plain lexing with nothing pending
    if (run_fresh) begin
      if (in_byte == CH_NUL) begin
        fresh_emit = 1'b1;
        fresh_kind = K_END;
        fresh_len  = LEN_W'(0);
      end else begin
        pos_next = pos_inc;
        if (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_CR) begin
          fresh_emit = 1'b0;
        end else if (in_byte == CH_NL) begin
          line_next = line_inc;
        end else if (single_hit) begin
          fresh_emit = 1'b1;
          fresh_kind = single_kind;
        end else if (pair_code != P_NONE) begin
          pend_next       = pair_code;
          pend_start_next = START_W'(pos);
        end else begin
          fresh_emit = 1'b1;
          fresh_kind = K_ERROR;
        end
      end
    end
  end

  // Order the tokens and mark the last one of this byte
  always_comb begin
    tok0.line   = LINE_W'(line);
    tok1.line   = LINE_W'(line);
    tok1.kind   = fresh_kind;
    tok1.start  = fresh_start;
    tok1.length = fresh_len;
    tok1.last   = 1'b1;
    if (emit_pend) begin
      tok0.kind   = pend_kind;
      tok0.start  = pend_start;
      tok0.length = pend_len;
      tok0.last   = !fresh_emit;
      push_cnt    = fresh_emit ? 2'd2 : 2'd1;
    end else begin
      tok0.kind   = fresh_kind;
      tok0.start  = fresh_start;
      tok0.length = fresh_len;
      tok0.last   = 1'b1;
      push_cnt    = fresh_emit ? 2'd1 : 2'd0;
    end
  end

  // Input register and lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      pend       <= P_NONE;
      pend_start <= '0;
      in_comment <= 1'b0;
      pos        <= '0;
      line       <= LNC_W'(1);
    end else begin
      in_valid   <= in_valid_i && in_ready_i;
      pend       <= pend_next;
      pend_start <= pend_start_next;
      in_comment <= in_comment_next;
      pos        <= pos_next;
      line       <= line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_i && in_ready_i) begin
      in_byte <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/plex_fifo.sv
// Result queue for tokens: takes up to two per cycle, delivers one.
`timescale 1ns / 1ps
`default_nettype none

module plex_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       push_cnt,
  input  wire plex_pkg::token_t din0,
  input  wire plex_pkg::token_t din1,
  input  wire logic             pop,
  output plex_pkg::token_t      dout,
  output logic                  dout_valid,
  output logic                  room
);
  import plex_pkg::*;

  token_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head;
  logic [FIFO_AW-1:0] tail;
  logic [FIFO_CW-1:0] count;
  logic               do_pop;

  assign dout_valid = (count != '0);
  assign dout       = mem[head];
  assign do_pop     = pop && dout_valid;
  // Headroom check on the registered fill count keeps the input side off the output handshake
  assign room       = (count <= FIFO_CW'(FIFO_DEPTH - FIFO_ROOM));

  // Storage writes
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[tail] <= din0;
    end
    if (push_cnt == 2'd2) begin
      mem[tail + FIFO_AW'(1)] <= din1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + FIFO_AW'(push_cnt);
      head  <= head + FIFO_AW'(do_pop);
      count <= count + FIFO_CW'(push_cnt) - FIFO_CW'(do_pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/punctuation_operator_lexer_top.sv
// Top level of the punctuation and operator lexer.
`timescale 1ns / 1ps
`default_nettype none

// Lexes one source byte per transaction on the slave side and emits tokens for
// punctuation and one- or two-character operators on the master side, skipping
// whitespace and // comments and counting lines. A zero byte ends the source and
// gives an end token. A byte is registered on acceptance and decoded in the next
// cycle into zero, one or two tokens that go into an eight-entry result queue.
// Sustained rate is one byte per cycle while the queue has room; a byte that yields two
// tokens delivers them one at a time, so with the output always ready the throughput is set by the
// single-token read port of the queue, and the input stalls while fewer than four
// queue slots are free. A byte reaches the master side through the input register
// and the result queue.
module punctuation_operator_lexer_top #(
  parameter longint unsigned MAX_SOURCE_BYTES = 65536,
  parameter longint unsigned LINE_LIMIT       = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] source_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [4:0] token_kind, [20:5] token_start,
                                      // [22:21] token_length, [38:23] line_number, [39] 0
  output logic             m_tlast    // last_of_run
);
  import plex_pkg::*;

  token_t     tok0;
  token_t     tok1;
  token_t     head_tok;
  logic [1:0] push_cnt;
  logic       room;

  plex_core #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES),
    .LINE_LIMIT      (LINE_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid_i(s_tvalid),
    .in_ready_i(s_tready),
    .in_byte_i (s_tdata),
    .tok0      (tok0),
    .tok1      (tok1),
    .push_cnt  (push_cnt)
  );

  plex_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .din0      (tok0),
    .din1      (tok1),
    .pop       (m_tready),
    .dout      (head_tok),
    .dout_valid(m_tvalid),
    .room      (room)
  );

  assign s_tready = room;

  // Pack the token onto the master side
  assign m_tdata = {1'b0, head_tok.line, head_tok.length, head_tok.start, head_tok.kind};
  assign m_tlast = head_tok.last;

endmodule

`default_nettype wire
